>>> sv/sgcl_pkg.sv
// ============================================================================
// sgcl_pkg
// Shared types and constants for the small graph canonical labeler.
// ============================================================================
`default_nettype none

package sgcl_pkg;

  localparam int ADJ_W      = 64;  // packed adjacency matrix width
  localparam int CNT_W      = 4;   // vertex count field width
  localparam int ROW_STRIDE = 8;   // bit row*ROW_STRIDE+column

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } sgcl_state_e;

  // One step of the permutation sequencer.
  typedef struct packed {
    logic active;  // perm bus carries a permutation to evaluate
    logic last;    // this is the final permutation
  } sgcl_step_t;

endpackage

`default_nettype wire

>>> sv/sgcl_perm_gen.sv
// ============================================================================
// sgcl_perm_gen
// Permutation sequencer: steps through all vertex permutations in
// lexicographic order, one per cycle, starting from the identity.
// ============================================================================
`default_nettype none

module sgcl_perm_gen
  import sgcl_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int IDX_W        = $clog2(MAX_VERTICES),
  parameter int NUM_W        = $clog2(MAX_VERTICES + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire  [NUM_W-1:0]                   num_i,
  output sgcl_step_t                         step_o,
  output logic [MAX_VERTICES*IDX_W-1:0]      perm_o
);

  logic [IDX_W-1:0] perm_q [MAX_VERTICES];
  logic [IDX_W-1:0] perm_d [MAX_VERTICES];
  logic             active_q, active_d;
  logic             has_pivot;

  always_comb begin
    logic [IDX_W-1:0] piv;
    logic [IDX_W-1:0] piv_m1;
    logic [IDX_W-1:0] swp;
    logic [IDX_W-1:0] pval;
    logic [IDX_W-1:0] swapped [MAX_VERTICES];
    int               src;
    has_pivot = 1'b0;
    piv       = '0;
    swp       = '0;
    // pivot: rightmost ascent inside the first n entries
    for (int k = 1; k < MAX_VERTICES; k++) begin
      if ((k < int'(num_i)) && (perm_q[k-1] < perm_q[k])) begin
        has_pivot = 1'b1;
        piv       = IDX_W'(k);
      end
    end
    piv_m1 = piv - IDX_W'(1);
    pval   = perm_q[piv_m1];
    // rightmost entry right of the pivot that exceeds it
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if ((k >= int'(piv)) && (k < int'(num_i)) && (perm_q[k] > pval)) begin
        swp = IDX_W'(k);
      end
    end
    for (int k = 0; k < MAX_VERTICES; k++) begin
      swapped[k] = perm_q[k];
    end
    swapped[piv_m1] = perm_q[swp];
    swapped[swp]    = pval;
    // reverse the suffix after the pivot
    for (int k = 0; k < MAX_VERTICES; k++) begin
      src = int'(piv) + int'(num_i) - 1 - k;
      if ((k >= int'(piv)) && (k < int'(num_i))) begin
        perm_d[k] = swapped[src[IDX_W-1:0]];
      end else begin
        perm_d[k] = swapped[k];
      end
    end
    active_d = active_q && has_pivot;
    if (start_i) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        perm_d[k] = IDX_W'(k);
      end
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      perm_q[k] <= perm_d[k];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      perm_o[k*IDX_W +: IDX_W] = perm_q[k];
    end
    step_o.active = active_q;
    step_o.last   = !has_pivot;
  end

  // entry 0 never exceeds the last vertex index in use
  a_perm0_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && (num_i != '0) |-> (int'(perm_q[0]) < int'(num_i)))
    else $error("perm entry 0 out of range");

  // start always restarts from the identity
  a_start_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (perm_q[0] == '0) && active_q)
    else $error("sequencer did not restart");

  // a finished sequence stops the sequencer
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !has_pivot && !start_i |=> !active_q)
    else $error("sequencer ran past last permutation");

endmodule

`default_nettype wire

>>> sv/sgcl_relabel_cmp.sv
// ============================================================================
// sgcl_relabel_cmp
// Relabel and compare unit: relabels the matrix under one permutation
// per cycle, then keeps the row-major greatest matrix seen.
// ============================================================================
`default_nettype none

module sgcl_relabel_cmp
  import sgcl_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int IDX_W        = $clog2(MAX_VERTICES),
  parameter int NUM_W        = $clog2(MAX_VERTICES + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  sgcl_step_t                         step_i,
  input  wire  [MAX_VERTICES*IDX_W-1:0]      perm_i,
  input  wire  [NUM_W-1:0]                   num_i,
  input  wire  [ADJ_W-1:0]                   adj_i,
  output logic [ADJ_W-1:0]                   best_o,
  output logic                               done_o
);

  logic [ADJ_W-1:0] cand_d, cand_q;
  logic [ADJ_W-1:0] best_q;
  logic             cand_vld_q, cand_last_q;
  logic             done_q;
  logic             greater;

  // relabel: cell (i,j) takes input cell (p[i], p[j])
  always_comb begin
    logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
    logic [IDX_W-1:0]        p    [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] sel;
    for (int r = 0; r < MAX_VERTICES; r++) begin
      rows[r] = adj_i[r*ROW_STRIDE +: MAX_VERTICES];
      p[r]    = perm_i[r*IDX_W +: IDX_W];
    end
    cand_d = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      sel = rows[p[i]];
      for (int j = 0; j < MAX_VERTICES; j++) begin
        cand_d[i*ROW_STRIDE + j] = sel[p[j]] && (i < int'(num_i)) && (j < int'(num_i));
      end
    end
  end

  // lowest differing bit decides; candidate wins if it holds the set bit
  always_comb begin
    logic [ADJ_W-1:0] diff;
    logic [ADJ_W-1:0] first;
    diff    = cand_q ^ best_q;
    first   = diff & (~diff + ADJ_W'(1));
    greater = |(cand_q & first);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_vld_q  <= 1'b0;
      cand_last_q <= 1'b0;
      done_q      <= 1'b0;
      best_q      <= '0;
    end else begin
      cand_vld_q  <= step_i.active && !start_i;
      cand_last_q <= step_i.last;
      done_q      <= cand_vld_q && cand_last_q && !start_i;
      if (start_i) begin
        best_q <= '0;
      end else if (cand_vld_q && greater) begin
        best_q <= cand_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign best_o = best_q;
  assign done_o = done_q;

  // a greater candidate replaces the kept matrix
  a_best_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_vld_q && greater |=> (best_q == $past(cand_q)))
    else $error("best not updated by greater candidate");

  // done is raised in the cycle after a last valid candidate
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cand_vld_q && cand_last_q))
    else $error("done without last candidate");

  // best only changes on start or on a valid greater candidate
  a_best_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i && !(cand_vld_q && greater) |=> $stable(best_q))
    else $error("best changed unexpectedly");

endmodule

`default_nettype wire

>>> sv/small_graph_canonical_label_top.sv
// ============================================================================
// small_graph_canonical_label_top
// Brute-force canonical labeling of a small directed graph.
// ============================================================================
// Search: n is clamped to MAX_VERTICES; n of 0 or 1 takes one permutation.
//   The relabel/compare unit evaluates one permutation per cycle and the input
//   is held off until the result is loaded into the output register, which
//   waits while a previous result is still unaccepted.
// Reset: asynchronous active low, clears control state; no memories to clear.
`default_nettype none

module small_graph_canonical_label_top
  import sgcl_pkg::*;
#(
  parameter int MAX_VERTICES = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [CNT_W-1:0]  vertex_count_i,
  input  wire  [ADJ_W-1:0]  adjacency_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [ADJ_W-1:0]  canonical_adjacency_o
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int NUM_W = $clog2(MAX_VERTICES + 1);

  sgcl_state_e                   state_q, state_d;
  logic [NUM_W-1:0]              num_q;
  logic [ADJ_W-1:0]              adj_q;
  logic [ADJ_W-1:0]              out_q;
  logic                          out_vld_q, out_vld_d;
  logic                          load_out;
  logic                          start;
  logic                          done;
  logic [ADJ_W-1:0]              best;
  sgcl_step_t                    step;
  logic [MAX_VERTICES*IDX_W-1:0] perm;

  assign start = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          if (!out_vld_q || out_ready_i) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_vld_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_vld_d = (out_vld_q && !out_ready_i) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      adj_q <= adjacency_i;
      if (vertex_count_i > CNT_W'(MAX_VERTICES)) begin
        num_q <= NUM_W'(MAX_VERTICES);
      end else begin
        num_q <= vertex_count_i[NUM_W-1:0];
      end
    end
    if (load_out) begin
      out_q <= best;
    end
  end

  sgcl_perm_gen #(
    .MAX_VERTICES (MAX_VERTICES),
    .IDX_W        (IDX_W),
    .NUM_W        (NUM_W)
  ) u_perm_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (num_q),
    .step_o  (step),
    .perm_o  (perm)
  );

  sgcl_relabel_cmp #(
    .MAX_VERTICES (MAX_VERTICES),
    .IDX_W        (IDX_W),
    .NUM_W        (NUM_W)
  ) u_relabel_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .step_i  (step),
    .perm_i  (perm),
    .num_i   (num_q),
    .adj_i   (adj_q),
    .best_o  (best),
    .done_o  (done)
  );

  assign out_valid_o           = out_vld_q;
  assign canonical_adjacency_o = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_RUN) && !in_ready_o)
    else $error("accepted transaction did not start a run");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == ST_RUN))
    else $error("search finished outside a run");

  a_hold_only_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_vld_q)
    else $error("holding result with free output register");

endmodule

`default_nettype wire

>>> tb/sv/tb_small_graph_canonical_label_top.sv
// ============================================================================
// tb_small_graph_canonical_label_top
// Self-checking bench for the brute-force graph canonical labeler: directed
// corner graphs, then random graphs of mostly small order, with random input
// gaps and output backpressure. Every result is compared against an
// exhaustive permutation search done inside the bench.
// ============================================================================

module tb_small_graph_canonical_label_top;
  import sgcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VTX        = 8;
  localparam int NUM_RANDOM     = 100;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic              drain;  // wait for all outstanding results first
    logic [7:0]        gap;    // idle cycles after this transaction
    logic [CNT_W-1:0]  cnt;
    logic [ADJ_W-1:0]  adj;
  } graph_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [CNT_W-1:0]  vertex_count_i = '0;
  logic [ADJ_W-1:0]  adjacency_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ADJ_W-1:0]  canonical_adjacency_o;

  graph_req_t        pending_graphs[$];
  logic [ADJ_W-1:0]  canon_expect[$];
  logic [ADJ_W-1:0]  want;
  logic              in_fire_q = 1'b0;
  int unsigned       idle_left = 0;
  int unsigned       rdy_left = 0;
  int unsigned       error_count = 0;

  small_graph_canonical_label_top #(
    .MAX_VERTICES (MAX_VTX)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .vertex_count_i        (vertex_count_i),
    .adjacency_i           (adjacency_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .canonical_adjacency_o (canonical_adjacency_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else             return $urandom_range(20, 80);
  endfunction

  // Exhaustive search: greatest relabeled matrix, row-major, lower bit index
  // is the more significant cell.
  function automatic logic [ADJ_W-1:0] best_relabeling(
    input logic [CNT_W-1:0] cnt,
    input logic [ADJ_W-1:0] adj
  );
    int               nv;
    int               ord [MAX_VTX];
    int               i, j, k, t;
    logic [ADJ_W-1:0] cand, best, diff, low;
    bit               more;
    nv = (cnt > MAX_VTX) ? MAX_VTX : int'(cnt);
    best = '0;
    for (i = 0; i < MAX_VTX; i++) ord[i] = i;
    more = 1'b1;
    while (more) begin
      cand = '0;
      for (i = 0; i < nv; i++)
        for (j = 0; j < nv; j++)
          cand[i*ROW_STRIDE + j] = adj[ord[i]*ROW_STRIDE + ord[j]];
      diff = cand ^ best;
      low  = diff & (~diff + 1'b1);
      if ((cand & low) != '0) best = cand;
      // step to the next ordering in lexicographic sequence
      more = 1'b0;
      if (nv > 1) begin
        k = nv - 2;
        while (k >= 0 && ord[k] > ord[k+1]) k--;
        if (k >= 0) begin
          j = nv - 1;
          while (ord[j] < ord[k]) j--;
          t = ord[k]; ord[k] = ord[j]; ord[j] = t;
          i = k + 1;
          j = nv - 1;
          while (i < j) begin
            t = ord[i]; ord[i] = ord[j]; ord[j] = t;
            i++;
            j--;
          end
          more = 1'b1;
        end
      end
    end
    return best;
  endfunction

  task automatic add_graph(input int cnt, input logic [ADJ_W-1:0] adj,
                           input int unsigned gap, input bit drain);
    graph_req_t g;
    g.cnt   = cnt[CNT_W-1:0];
    g.adj   = adj;
    g.gap   = (gap > 255) ? 8'd255 : gap[7:0];
    g.drain = drain;
    pending_graphs.push_back(g);
  endtask

  // Sender: new transaction only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (idle_left != 0) begin
        in_valid_i <= 1'b0;
        idle_left  <= idle_left - 1;
      end else if (pending_graphs.size() != 0 &&
                   !(pending_graphs[0].drain && canon_expect.size() != 0)) begin
        vertex_count_i <= pending_graphs[0].cnt;
        adjacency_i    <= pending_graphs[0].adj;
        in_valid_i     <= 1'b1;
        idle_left      <= pending_graphs[0].gap;
        void'(pending_graphs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk_i) begin
    if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      rdy_left    <= gap_len();
    end
  end

  // Monitor: check results before recording new expectations.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (canon_expect.size() == 0) begin
          flag_error($sformatf("unexpected result %h", canonical_adjacency_o));
        end else begin
          want = canon_expect.pop_front();
          if (canonical_adjacency_o !== want)
            flag_error($sformatf("canonical_adjacency got %h want %h",
                                 canonical_adjacency_o, want));
        end
      end
      if (in_valid_i && in_ready_o)
        canon_expect.push_back(best_relabeling(vertex_count_i, adjacency_i));
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    int          n, r;
    bit          calm;
    logic [ADJ_W-1:0] a;

    // corner graphs
    add_graph(0,  '1, 0, 1'b0);                         // no vertices
    add_graph(1,  '1, 1, 1'b0);                         // lone self loop
    add_graph(1,  ~64'h1, 0, 1'b0);                     // only outside cells set
    add_graph(2,  64'h2, 0, 1'b0);                      // single edge 0->1
    add_graph(2,  64'h100, 2, 1'b0);                    // single edge 1->0
    add_graph(3,  64'hFFFF_FFFF_FFF8_F8F8, 0, 1'b0);    // square empty, rest full
    add_graph(8,  '0, 0, 1'b0);                         // edgeless, full order
    add_graph(8,  '1, 3, 1'b1);                         // complete with loops
    add_graph(15, {$urandom, $urandom}, 0, 1'b0);       // count saturates
    add_graph(9,  {$urandom, $urandom}, 0, 1'b0);
    add_graph(4,  64'h0000_0001_0804_0200, 0, 1'b0);    // loops on 1, 2 and 3
    add_graph(5,  64'hAAAA_AAAA_AAAA_AAAA, 5, 1'b0);
    add_graph(5,  64'h5555_5555_5555_5555, 0, 1'b0);
    add_graph(6,  64'h0000_1F2F_373B_3D3E, 0, 1'b0);    // complete, no loops
    add_graph(7,  {$urandom, $urandom}, 1, 1'b0);
    add_graph(3,  64'h0000_0000_0001_0001, 0, 1'b0);    // loop on 0, edge 2->0

    calm = 1'b0;
    for (int idx = 0; idx < NUM_RANDOM; idx++) begin
      if ($urandom_range(0, 14) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (idx == 30 || idx == 70) n = $urandom_range(8, 15);
      else if (r < 4)             n = 7;
      else if (r < 10)            n = $urandom_range(0, 1);
      else                        n = $urandom_range(2, 6);
      case ($urandom_range(0, 3))
        0:       a = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        1:       a = {$urandom, $urandom} | {$urandom, $urandom};
        default: a = {$urandom, $urandom};
      endcase
      add_graph(n, a, calm ? 0 : gap_len(), idx == 50);
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_graphs.size() != 0 || in_valid_i) @(negedge clk_i);
    while (canon_expect.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> small_graph_canonical_label_top.f
sv/sgcl_pkg.sv
sv/sgcl_perm_gen.sv
sv/sgcl_relabel_cmp.sv
sv/small_graph_canonical_label_top.sv
tb/sv/tb_small_graph_canonical_label_top.sv
